>>> sv/pump_channel_run_controller_top_defines.svh
// Assertion macros for the pump channel run controller.
// Used by the top level only; no other dependencies.
`ifndef PUMP_CHANNEL_RUN_CONTROLLER_TOP_DEFINES_SVH
`define PUMP_CHANNEL_RUN_CONTROLLER_TOP_DEFINES_SVH

// Assert that cond implies the next-cycle consequence.
`define PCR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

// Assert an invariant while out of reset.
`define PCR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

>>> sv/pcr_pkg.sv
// Package for the pump channel run controller: widths, codes, record type.
// No dependencies.
`default_nettype none
package pcr_pkg;
  localparam int CHANNELS = 8;
  localparam int CW = $clog2(CHANNELS);

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_RUN   = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_ALL   = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  localparam logic [2:0] RC_OK    = 3'd0;
  localparam logic [2:0] RC_BADLEN = 3'd1;
  localparam logic [2:0] RC_NOTFND = 3'd2;
  localparam logic [2:0] RC_COOL  = 3'd3;
  localparam logic [2:0] RC_ALRON = 3'd4;
  localparam logic [2:0] RC_UNDER = 3'd5;
  localparam logic [2:0] RC_OVER  = 3'd6;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_COOL = 2'd2;

  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_LIMIT = 3'd1;
  localparam logic [2:0] REG_COOLD = 3'd2;
  localparam logic [2:0] REG_LOW   = 3'd3;
  localparam logic [2:0] REG_HIGH  = 3'd4;
  localparam logic [2:0] REG_CHECK = 3'd5;

  // per-channel record held in the channel memory
  typedef struct packed {
    logic [1:0]  mode;
    logic        on;
    logic [47:0] start_stamp;
    logic [31:0] run_length;
    logic [47:0] stop_stamp;
    logic [47:0] total_on;
    logic [31:0] last_length;
    logic [31:0] starts;
    logic [31:0] failures;
    logic [31:0] over_ev;
    logic [31:0] under_ev;
    logic        last_good;
    logic        cmd_good;
  } chan_rec_t;

  localparam int REC_W = $bits(chan_rec_t);
endpackage
`default_nettype wire

>>> sv/pcr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/pcr_cfg.sv
// Configuration register file of the pump channel run controller.
// Depends on pcr_pkg.
`default_nettype none
module pcr_cfg import pcr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        we,
  input  wire logic [2:0]  idx,
  input  wire logic [31:0] wdata,
  output logic [CW:0]      active_n,
  output logic [31:0]      limit,
  output logic [31:0]      cooldown,
  output logic signed [15:0] low_ma,
  output logic signed [15:0] high_ma,
  output logic             check_on
);
  logic [3:0] count_r;
  logic [31:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; limit_r <= 32'd60000; cooldown <= 32'd5000;
      low_ma <= '0; high_ma <= 16'sd32767; check_on <= 1'b0;
    end else if (we) begin
      unique case (idx)
        REG_COUNT: count_r  <= wdata[3:0];
        REG_LIMIT: limit_r  <= wdata;
        REG_COOLD: cooldown <= wdata;
        REG_LOW:   low_ma   <= wdata[15:0];
        REG_HIGH:  high_ma  <= wdata[15:0];
        REG_CHECK: check_on <= wdata[0];
        default: ;
      endcase
    end
  end

  // clamp count to CHANNELS, zero limit acts as 1
  always_comb begin
    if ({28'd0, count_r} > 32'(CHANNELS)) active_n = (CW+1)'(CHANNELS);
    else active_n = (CW+1)'(count_r);
    limit = (limit_r == '0) ? 32'd1 : limit_r;
  end
endmodule
`default_nettype wire

>>> sv/pcr_ctrl.sv
// Sequencer: read-modify-write of channel records in the channel memory.
// Depends on pcr_pkg and pcr_ram.
`default_nettype none
module pcr_ctrl import pcr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [2:0]  chan,
  input  wire logic [31:0] run_ms,
  input  wire logic signed [15:0] sample,
  input  wire logic        sample_valid,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [222:0]     out_data,
  input  wire logic [CW:0] active_n,
  input  wire logic [31:0] limit,
  input  wire logic [31:0] cooldown,
  input  wire logic signed [15:0] low_ma,
  input  wire logic signed [15:0] high_ma,
  input  wire logic        check_on
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_WAIT, S_MOD, S_FIN, S_OUT} st_t;

  st_t st_r;
  logic [2:0] cmd_r, chan_r, code_r;
  logic [31:0] len_r;
  logic signed [15:0] smp_r;
  logic sv_r;
  logic [CW-1:0] idx_r;
  logic [47:0] clock_r;
  logic [CHANNELS-1:0] onmask_r;
  logic found_r;
  logic [222:0] data_r;
  logic [222:0] res;

  logic we;
  chan_rec_t wrec, rrec, nrec;
  logic [2:0] ncode;
  logic [47:0] el_start, el_stop;

  pcr_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS)) u_mem (
    .clk(clk), .we(we), .waddr(idx_r), .wdata(wrec),
    .raddr(idx_r), .rdata(rrec)
  );

  // record update for the entry just read
  always_comb begin
    logic halt, runok;
    nrec = rrec;
    ncode = RC_OK;
    halt = 1'b0;
    runok = 1'b0;
    el_start = clock_r - rrec.start_stamp;
    el_stop = clock_r - rrec.stop_stamp;
    case (cmd_r)
      CMD_TICK: halt = rrec.on && (el_start >= {16'd0, rrec.run_length});
      CMD_STOP, CMD_ALL: halt = rrec.on;
      CMD_QUERY: if (rrec.mode == MODE_COOL && el_stop >= {16'd0, cooldown})
        nrec.mode = MODE_OFF;
      CMD_RUN: begin
        runok = 1'b1;
        if (rrec.mode == MODE_COOL && el_stop >= {16'd0, cooldown}) nrec.mode = MODE_OFF;
        if (nrec.mode == MODE_COOL) begin
          ncode = RC_COOL; runok = 1'b0;
        end else if (rrec.on) begin
          ncode = RC_ALRON; runok = 1'b0;
        end else begin
          nrec.cmd_good = 1'b0; nrec.last_good = 1'b0;
          if (check_on && sv_r && (smp_r < low_ma || smp_r > high_ma)) begin
            runok = 1'b0;
            nrec.failures = rrec.failures + 32'd1;
            if (smp_r < low_ma) begin
              nrec.under_ev = rrec.under_ev + 32'd1; ncode = RC_UNDER;
            end else begin
              nrec.over_ev = rrec.over_ev + 32'd1; ncode = RC_OVER;
            end
          end
        end
        if (runok) begin
          nrec.mode = MODE_ON; nrec.on = 1'b1; nrec.start_stamp = clock_r;
          nrec.run_length = (len_r > limit) ? limit : len_r;
          nrec.last_good = 1'b1; nrec.cmd_good = 1'b1;
          nrec.starts = rrec.starts + 32'd1;
        end
      end
      default: ;
    endcase
    if (halt) begin
      nrec.on = 1'b0; nrec.mode = MODE_COOL; nrec.stop_stamp = clock_r;
      nrec.total_on = rrec.total_on + el_start;
      nrec.last_length = el_start[31:0];
      nrec.last_good = rrec.cmd_good;
    end
  end

  // result record from the reread entry, first field lowest
  always_comb begin
    res = '0;
    res[2:0] = code_r;
    res[13:6] = 8'(onmask_r);
    if (found_r) begin
      res[5:3] = {rrec.on, rrec.mode};
      res[45:14] = rrec.starts;
      res[77:46] = rrec.failures;
      res[109:78] = rrec.over_ev;
      res[141:110] = rrec.under_ev;
      res[173:142] = rrec.last_length;
      res[221:174] = rrec.total_on;
      res[222] = rrec.last_good;
    end
  end

  // clearing pass writes zero records after reset
  assign we = (st_r == S_MOD) || (st_r == S_CLR);
  assign wrec = (st_r == S_CLR) ? chan_rec_t'('0) : nrec;
  assign in_ready = (st_r == S_IDLE) && !out_valid;
  assign out_data = data_r;

  // sequencer; scan commands walk idx_r over active channels
  always_ff @(posedge clk) begin
    logic [CHANNELS-1:0] m;
    m = onmask_r;
    if (!rst_n) begin
      st_r <= S_CLR; idx_r <= '0;
      out_valid <= 1'b0; clock_r <= '0; onmask_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          if (idx_r == CW'(CHANNELS - 1)) begin
            idx_r <= '0; st_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_IDLE: if (in_valid && in_ready) begin
          cmd_r <= cmd; chan_r <= chan; len_r <= run_ms; smp_r <= sample;
          sv_r <= sample_valid; code_r <= RC_OK;
          found_r <= {1'b0, chan} < 4'(active_n);
          if (cmd == CMD_TICK) clock_r <= clock_r + 48'd1;
          if (cmd == CMD_TICK || cmd == CMD_ALL) begin
            idx_r <= '0;
            st_r <= (active_n == '0) ? S_FIN : S_READ;
          end else if (cmd == CMD_RUN && run_ms == '0) begin
            idx_r <= chan[CW-1:0];
            code_r <= RC_BADLEN; st_r <= S_FIN;
          end else if (({1'b0, chan} >= 4'(active_n)) &&
                       (cmd == CMD_RUN || cmd == CMD_STOP || cmd == CMD_QUERY)) begin
            idx_r <= chan[CW-1:0];
            code_r <= RC_NOTFND; st_r <= S_FIN;
          end else begin
            idx_r <= chan[CW-1:0];
            st_r <= ({1'b0, chan} >= 4'(active_n)) ? S_FIN : S_READ;
          end
        end
        S_READ: st_r <= S_WAIT;
        S_WAIT: st_r <= S_MOD;
        S_MOD: begin
          m[idx_r] = nrec.on;
          onmask_r <= m;
          if (cmd_r == CMD_RUN) code_r <= ncode;
          if ((cmd_r == CMD_TICK || cmd_r == CMD_ALL) &&
              (32'(idx_r) + 32'd1 < 32'(active_n))) begin
            idx_r <= idx_r + CW'(1); st_r <= S_READ;
          end else begin
            idx_r <= chan_r[CW-1:0]; st_r <= S_FIN;
          end
        end
        S_FIN: st_r <= S_OUT;
        S_OUT: begin
          data_r <= res;
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/pump_channel_run_controller_top.sv
// Channel    Dir  Transfer when           Payload
// in_        in   in_tvalid & in_tready   command, channel, run_ms, sample
// out_       out  out_tvalid & out_tready result record
// cfg_       in   cfg_we                  register write
// Run, stop, query and unused commands on an active channel pass the read, wait,
// modify, finish and output states; refusals of zero length or unknown channel
// skip to finish and output; tick and stop all repeat read, wait and modify per
// active channel of the single channel memory. Reset restores the registers; a
// write pass after reset zeroes the channel memory, with in_tready low meanwhile.
// An item is taken only after the previous result transfers.
// Depends on pcr_pkg, pcr_cfg, pcr_ctrl, pcr_ram and the defines header.
`include "pump_channel_run_controller_top_defines.svh"
`default_nettype none
module pump_channel_run_controller_top import pcr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command[2:0] channel[5:3] run_ms[37:6] sample_ma[53:38] sample_valid[54]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_code, channel_state, pump_on, drive_mask, starts, failures,
  // overcurrent, undercurrent, last_run_length, run_time_total, last_run_good
  output logic [223:0]     out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  logic [CW:0] active_n;
  logic [31:0] limit, cooldown;
  logic signed [15:0] low_ma, high_ma;
  logic check_on;
  logic [222:0] d;

  pcr_cfg u_cfg (.clk, .rst_n, .we(cfg_we), .idx(cfg_index), .wdata(cfg_wdata),
    .active_n, .limit, .cooldown, .low_ma, .high_ma, .check_on);

  pcr_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .cmd(in_tdata[2:0]), .chan(in_tdata[5:3]), .run_ms(in_tdata[37:6]),
    .sample(in_tdata[53:38]), .sample_valid(in_tdata[54]),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(d),
    .active_n, .limit, .cooldown, .low_ma, .high_ma, .check_on);

  assign out_tdata = {1'b0, d};

  `PCR_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `PCR_ASSERT_ALWAYS(a_no_take, clk, rst_n, !(in_tready && out_tvalid), "input taken while busy")
endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for pump_channel_run_controller_top: directed cases, then random
// command streams under three idle patterns, checked against an in-bench channel model.
// Depends on pcr_pkg and the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import pcr_pkg::*;

  // result record, first field in the lowest bits
  typedef struct packed {
    logic        last_good;
    logic [47:0] run_total;
    logic [31:0] last_len;
    logic [31:0] under_cnt;
    logic [31:0] over_cnt;
    logic [31:0] fail_cnt;
    logic [31:0] start_cnt;
    logic [7:0]  mask;
    logic        on;
    logic [1:0]  state;
    logic [2:0]  code;
  } pump_result_t;

  localparam int CYCLE_LIMIT = 1000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [55:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = REG_COUNT;
  logic [31:0]  cfg_wdata = '0;

  pump_channel_run_controller_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial forever #4 clk = ~clk;

  // shadow configuration
  logic [3:0]         m_count;
  logic [31:0]        m_limit;
  logic [31:0]        m_cooldown;
  logic signed [15:0] m_low;
  logic signed [15:0] m_high;
  logic               m_check;

  // shadow channel state
  logic [47:0] m_clock;
  logic [1:0]  m_mode [8];
  logic        m_on [8];
  logic [47:0] m_start [8];
  logic [31:0] m_len [8];
  logic [47:0] m_stop [8];
  logic [47:0] m_total [8];
  logic [31:0] m_last [8];
  logic [31:0] m_starts [8];
  logic [31:0] m_fails [8];
  logic [31:0] m_over [8];
  logic [31:0] m_under [8];
  logic        m_lgood [8];
  logic        m_cgood [8];

  pump_result_t expected_results [$];
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, results_seen);
  endtask

  function automatic void model_reset();
    m_count = 0; m_limit = 60000; m_cooldown = 5000;
    m_low = 0; m_high = 16'sd32767; m_check = 0; m_clock = 0;
    for (int i = 0; i < 8; i++) begin
      m_mode[i] = MODE_OFF; m_on[i] = 0; m_start[i] = 0; m_len[i] = 0;
      m_stop[i] = 0; m_total[i] = 0; m_last[i] = 0; m_starts[i] = 0;
      m_fails[i] = 0; m_over[i] = 0; m_under[i] = 0; m_lgood[i] = 0; m_cgood[i] = 0;
    end
  endfunction

  function automatic void halt_pump(int c);
    logic [47:0] ran;
    if (!m_on[c]) return;
    ran = m_clock - m_start[c];
    m_on[c] = 0; m_mode[c] = MODE_COOL; m_stop[c] = m_clock;
    m_total[c] = m_total[c] + ran;
    m_last[c] = ran[31:0];
    m_lgood[c] = m_cgood[c];
  endfunction

  function automatic void settle_pump(int c);
    logic [47:0] off_for;
    off_for = m_clock - m_stop[c];
    if (m_mode[c] == MODE_COOL && off_for >= {16'd0, m_cooldown}) m_mode[c] = MODE_OFF;
  endfunction

  function automatic logic [2:0] start_pump(int c, logic [31:0] len,
                                            logic signed [15:0] smp, logic vld);
    logic [31:0] lim;
    lim = (m_limit == 0) ? 32'd1 : m_limit;
    if (m_mode[c] == MODE_COOL) begin
      settle_pump(c);
      if (m_mode[c] == MODE_COOL) return RC_COOL;
    end
    if (m_on[c]) return RC_ALRON;
    if (len > lim) len = lim;
    m_cgood[c] = 0; m_lgood[c] = 0;
    if (m_check && vld && (smp < m_low || smp > m_high)) begin
      m_fails[c]++;
      if (smp < m_low) begin
        m_under[c]++;
        return RC_UNDER;
      end
      m_over[c]++;
      return RC_OVER;
    end
    m_mode[c] = MODE_ON; m_on[c] = 1; m_start[c] = m_clock; m_len[c] = len;
    m_lgood[c] = 1; m_cgood[c] = 1; m_starts[c]++;
    return RC_OK;
  endfunction

  function automatic pump_result_t predict_pump(logic [2:0] cmd, logic [2:0] ch,
      logic [31:0] len, logic signed [15:0] smp, logic vld);
    pump_result_t r;
    int n;
    logic found;
    n = (m_count > 8) ? 8 : m_count;
    found = ch < n;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        m_clock = m_clock + 1;
        for (int i = 0; i < n; i++)
          if (m_on[i] && (m_clock - m_start[i]) >= {16'd0, m_len[i]}) halt_pump(i);
      end
      CMD_RUN: begin
        if (len == 0) r.code = RC_BADLEN;
        else if (!found) r.code = RC_NOTFND;
        else r.code = start_pump(ch, len, smp, vld);
      end
      CMD_STOP: if (!found) r.code = RC_NOTFND; else halt_pump(ch);
      CMD_ALL: for (int i = 0; i < n; i++) halt_pump(i);
      CMD_QUERY: if (!found) r.code = RC_NOTFND; else settle_pump(ch);
      default: ;
    endcase
    for (int i = 0; i < 8; i++) r.mask[i] = m_on[i];
    if (found) begin
      r.state = m_mode[ch]; r.on = m_on[ch]; r.start_cnt = m_starts[ch];
      r.fail_cnt = m_fails[ch]; r.over_cnt = m_over[ch]; r.under_cnt = m_under[ch];
      r.last_len = m_last[ch]; r.run_total = m_total[ch]; r.last_good = m_lgood[ch];
    end
    return r;
  endfunction

  // send one command; returns at the edge where it transferred
  task automatic send_cmd(logic [2:0] cmd, logic [2:0] ch, logic [31:0] len,
                          logic [15:0] smp, logic vld);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, vld, smp, len, ch, cmd};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_pump(cmd, ch, len, smp, vld));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COUNT: m_count = val[3:0];
      REG_LIMIT: m_limit = val;
      REG_COOLD: m_cooldown = val;
      REG_LOW:   m_low = val[15:0];
      REG_HIGH:  m_high = val[15:0];
      REG_CHECK: m_check = val[0];
      default: ;
    endcase
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    pump_result_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[222:0];
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result %0h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.code !== want.code) report("result_code", got.code, want.code);
        if (got.state !== want.state) report("channel_state", got.state, want.state);
        if (got.on !== want.on) report("pump_on", got.on, want.on);
        if (got.mask !== want.mask) report("drive_mask", got.mask, want.mask);
        if (got.start_cnt !== want.start_cnt) report("starts", got.start_cnt, want.start_cnt);
        if (got.fail_cnt !== want.fail_cnt) report("failures", got.fail_cnt, want.fail_cnt);
        if (got.over_cnt !== want.over_cnt) report("overcurrent", got.over_cnt, want.over_cnt);
        if (got.under_cnt !== want.under_cnt)
          report("undercurrent", got.under_cnt, want.under_cnt);
        if (got.last_len !== want.last_len) report("last_len", got.last_len, want.last_len);
        if (got.run_total !== want.run_total) report("run_total", got.run_total, want.run_total);
        if (got.last_good !== want.last_good) report("last_good", got.last_good, want.last_good);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_not_found_at_reset();
    send_cmd(CMD_QUERY, 3'd0, 32'd0, 16'd0, 1'b0);
    send_cmd(CMD_RUN, 3'd0, 32'd10, 16'd0, 1'b0);
    send_cmd(CMD_STOP, 3'd7, 32'd0, 16'd0, 1'b0);
    send_cmd(CMD_TICK, 3'd0, 32'd0, 16'd0, 1'b0);
  endtask

  task automatic test_run_refusals();
    write_reg(REG_COUNT, 32'd8);
    write_reg(REG_COOLD, 32'd3);
    send_cmd(CMD_RUN, 3'd2, 32'd0, 16'd0, 1'b0);            // zero length first
    send_cmd(CMD_RUN, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1); // clamped to limit
    send_cmd(CMD_RUN, 3'd7, 32'd5, 16'd0, 1'b0);            // already on
    send_cmd(CMD_STOP, 3'd7, 32'd0, 16'd0, 1'b0);
    send_cmd(CMD_RUN, 3'd7, 32'd5, 16'd0, 1'b0);            // still cooling
    send_cmd(CMD_STOP, 3'd3, 32'd0, 16'd0, 1'b0);           // stop while off
    write_reg(REG_COUNT, 32'd4);
    send_cmd(CMD_QUERY, 3'd7, 32'd0, 16'd0, 1'b0);          // beyond count, not found
  endtask

  task automatic test_expiry_and_cooldown();
    write_reg(REG_LIMIT, 32'd0);                            // behaves as one ms
    send_cmd(CMD_RUN, 3'd1, 32'd100, 16'd0, 1'b0);
    send_cmd(CMD_TICK, 3'd0, 32'd0, 16'd0, 1'b0);
    write_reg(REG_LIMIT, 32'hFFFF_FFFF);
    send_cmd(CMD_RUN, 3'd0, 32'd2, 16'd0, 1'b0);
    repeat (6) send_cmd(CMD_TICK, 3'd0, 32'd0, 16'd0, 1'b0);
    send_cmd(CMD_QUERY, 3'd0, 32'd0, 16'd0, 1'b0);          // cooldown settles lazily
    send_cmd(CMD_RUN, 3'd0, 32'd1, 16'd0, 1'b0);
  endtask

  task automatic test_current_window();
    write_reg(REG_CHECK, 32'd1);
    write_reg(REG_LOW, 32'hFFFF_FF9C);                      // -100
    write_reg(REG_HIGH, 32'd100);
    send_cmd(CMD_RUN, 3'd2, 32'd9, 16'h8000, 1'b1);         // under
    send_cmd(CMD_RUN, 3'd2, 32'd9, 16'h7FFF, 1'b1);         // over
    send_cmd(CMD_RUN, 3'd2, 32'd9, 16'h7FFF, 1'b0);         // invalid sample passes
    write_reg(REG_LOW, 32'd200);                            // both limits broken
    send_cmd(CMD_RUN, 3'd3, 32'd9, 16'd150, 1'b1);
    write_reg(REG_LOW, 32'h0000_8000);
    write_reg(REG_HIGH, 32'h0000_7FFF);
    write_reg(REG_CHECK, 32'd0);
  endtask

  task automatic test_stop_all_and_unused();
    send_cmd(CMD_ALL, 3'd0, 32'd0, 16'd0, 1'b0);
    send_cmd(3'd5, 3'd2, 32'd0, 16'd0, 1'b0);
    send_cmd(3'd6, 3'd5, 32'd0, 16'd0, 1'b0);
    send_cmd(3'd7, 3'd7, 32'd0, 16'd0, 1'b0);
    write_reg(REG_COUNT, 32'd15);                           // above channel total
    send_cmd(CMD_ALL, 3'd7, 32'd0, 16'd0, 1'b0);
  endtask

  task automatic test_random_phase(int items, int s_idle, int r_idle);
    logic [2:0]  cmd;
    logic [31:0] len;
    int w;
    wait_drained();
    send_idle = s_idle; recv_idle = r_idle;
    write_reg(REG_COUNT, $urandom_range(15));
    write_reg(REG_LIMIT, ($urandom_range(9) == 0) ? $urandom : $urandom_range(40));
    write_reg(REG_COOLD, ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom_range(30));
    write_reg(REG_LOW, $urandom_range(1) ? 32'h8000 + $urandom_range(32767) : $urandom_range(500));
    write_reg(REG_HIGH, $urandom_range(1) ? 32'h7FFF - $urandom_range(32767) : $urandom);
    write_reg(REG_CHECK, $urandom_range(1));
    for (int k = 0; k < items; k++) begin
      w = $urandom_range(99);
      if (w < 40) cmd = CMD_TICK;
      else if (w < 70) cmd = CMD_RUN;
      else if (w < 80) cmd = CMD_STOP;
      else if (w < 84) cmd = CMD_ALL;
      else if (w < 96) cmd = CMD_QUERY;
      else cmd = 3'(5 + $urandom_range(2));
      w = $urandom_range(99);
      len = (w < 5) ? 32'd0 : (w < 80) ? $urandom_range(50) : $urandom;
      send_cmd(cmd, 3'($urandom_range(7)), len, 16'($urandom), 1'($urandom_range(1)));
      if (k == items / 2) wait_drained();                   // let the block run dry
    end
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_not_found_at_reset();
    test_run_refusals();
    test_expiry_and_cooldown();
    test_current_window();
    test_stop_all_and_unused();
    test_random_phase(250, 6, 78);
    test_random_phase(250, 78, 6);
    test_random_phase(250, 0, 0);
    test_random_phase(350, 6, 78);
    test_random_phase(350, 0, 0);
    wait_drained();
    $display("covered all commands and refusals, current window, expiry, cooldown and");
    $display("shrunk channel counts; %0d results checked", results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+sv
sv/pcr_pkg.sv
sv/pcr_ram.sv
sv/pcr_cfg.sv
sv/pcr_ctrl.sv
sv/pump_channel_run_controller_top.sv
verif/tb_top.sv
